>>> rtl/velocity_harmonic_exciter_unit_assert.svh
// Assertion macros for the velocity harmonic exciter.
// Included by the top level; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef VELOCITY_HARMONIC_EXCITER_UNIT_ASSERT_SVH
`define VELOCITY_HARMONIC_EXCITER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VHE_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("velocity exciter: implication check failed");
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VHE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("velocity exciter: next-cycle check failed");
`else
`define VHE_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define VHE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/vhe_pkg.sv
// Shared widths, register codes, pipeline control type and excitation function
// for the velocity harmonic exciter. No dependencies.
package vhe_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int VEL_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_RECORDED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET   = 2'd1;

    // Internal values carry 16 fraction bits.
    localparam int QF = 16;

    localparam int S_W     = 18;  // scaled sample, signed
    localparam int E_W     = 17;  // excitation, unsigned, 0..1.0
    localparam int DRIVE_W = 18;  // drive gain, unsigned, 1.0..3.0
    localparam int PROD_W  = 36;  // sample times drive, signed
    localparam int XM_W    = 18;  // magnitude of the driven sample
    localparam int DEN_W   = 19;  // shaper divisor
    localparam int NUM_W   = 35;  // shaper dividend including the rounding half
    localparam int Q_W     = 17;  // shaper quotient magnitude
    localparam int SH_W    = 18;  // shaped value, signed
    localparam int SUM_W   = 35;  // crossfade products and their sum, signed
    localparam int MIX_W   = 19;  // crossfade result, signed

    localparam logic [E_W-1:0] E_ONE = E_W'(1) << QF;

    // 65536 = 516 * 127 + 4, so d * 65536 / 127 = d * 516 + 4 * d / 127.
    localparam int E_STEP  = 516;
    localparam int VEL_MAX = 127;

    typedef struct packed {
        logic valid;
        logic last;
        logic bypass;
        logic neg;
    } pipe_ctl_t;

    // Rounded excitation level (d * 65536 + 63) / 127 for a velocity difference d.
    function automatic logic [E_W-1:0] excite_level(input logic [VEL_W-1:0] d);
        logic [9:0] t;
        logic [2:0] c;
        t = 10'({d, 2'b00}) + 10'(VEL_MAX / 2);
        c = 3'(t >= 10'(VEL_MAX)) + 3'(t >= 10'(2 * VEL_MAX))
          + 3'(t >= 10'(3 * VEL_MAX)) + 3'(t >= 10'(4 * VEL_MAX));
        return E_W'(d) * E_W'(E_STEP) + E_W'(c);
    endfunction

endpackage

>>> rtl/vhe_front.sv
// Front stages of the exciter: excitation and drive, sample scaling, the drive
// multiply, and the shaper's dividend and divisor. Depends on vhe_pkg.
module vhe_front #(
    parameter int SAMPLE_WIDTH = vhe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                                  last_in,
    input  logic [vhe_pkg::VEL_W-1:0]             recorded,
    input  logic [vhe_pkg::VEL_W-1:0]             target,
    output vhe_pkg::pipe_ctl_t                    ctl_o,
    output logic [vhe_pkg::NUM_W-1:0]             num_o,
    output logic [vhe_pkg::DEN_W-1:0]             den_o,
    output logic [vhe_pkg::S_W+vhe_pkg::E_W+SAMPLE_WIDTH-1:0] side_o
);
    import vhe_pkg::*;

    localparam int FRAC   = SAMPLE_WIDTH - 1;
    localparam int SIDE_W = S_W + E_W + SAMPLE_WIDTH;
    localparam logic [DEN_W-1:0] DEN_POS = DEN_W'(1) << QF;
    localparam logic [DEN_W-1:0] DEN_NEG = DEN_W'(1) << (QF + 1);
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (QF - 1);

    logic signed [S_W-1:0]   s_next;
    logic                    bypass_next;
    logic [E_W-1:0]          e_next;
    logic [DRIVE_W-1:0]      drive_next;

    pipe_ctl_t               ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg;
    logic [SIDE_W-1:0]       side_a_reg, side_b_reg, side_c_reg, side_d_reg;
    logic [DRIVE_W-1:0]      drive_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic [XM_W-1:0]         xmag_c_reg;
    logic [NUM_W-1:0]        num_d_reg;
    logic [DEN_W-1:0]        den_d_reg;

    logic [PROD_W-1:0]       prod_mag;
    logic [PROD_W-1:0]       prod_rnd;
    logic                    pos_next;
    logic [DEN_W-1:0]        den_next;
    logic [NUM_W-1:0]        num_next;

    always_comb begin
        bypass_next = (target <= recorded);
        e_next      = bypass_next ? '0 : excite_level(target - recorded);
        drive_next  = DRIVE_W'(E_ONE) + {e_next, 1'b0};
    end

    // Bring the sample to 16 fraction bits.
    if (FRAC <= QF) begin : g_scale_up
        localparam int UP = QF - FRAC;
        assign s_next = S_W'(sample_in) <<< UP;
    end else begin : g_scale_down
        localparam int DN = FRAC - QF;
        localparam logic [SAMPLE_WIDTH:0] HALF = (SAMPLE_WIDTH + 1)'(1) << (DN - 1);
        logic [SAMPLE_WIDTH-1:0] mag;
        logic [SAMPLE_WIDTH:0]   rsum;
        always_comb begin
            mag  = sample_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample_in)
                                             : SAMPLE_WIDTH'(sample_in);
            rsum = {1'b0, mag} + HALF;
            if (sample_in[SAMPLE_WIDTH-1]) begin
                s_next = -$signed({1'b0, rsum[DN+S_W-2:DN]});
            end else begin
                s_next = $signed({1'b0, rsum[DN+S_W-2:DN]});
            end
        end
    end

    // Driven sample rounded to 16 fraction bits, kept as sign and magnitude.
    always_comb begin
        prod_mag = prod_b_reg[PROD_W-1] ? PROD_W'(-prod_b_reg) : PROD_W'(prod_b_reg);
        prod_rnd = prod_mag + PROD_HALF;
    end

    // Positive x is shaped by x / (1 + x), the rest by x / (1 - x/2).
    always_comb begin
        pos_next = !ctl_c_reg.neg && (xmag_c_reg != '0);
        den_next = (pos_next ? DEN_POS : DEN_NEG) + DEN_W'(xmag_c_reg);
        num_next = (pos_next ? (NUM_W'(xmag_c_reg) << QF) : (NUM_W'(xmag_c_reg) << (QF + 1)))
                 + NUM_W'(den_next >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= '{valid: in_valid, last: last_in, bypass: bypass_next, neg: 1'b0};
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= '{valid: ctl_b_reg.valid, last: ctl_b_reg.last,
                           bypass: ctl_b_reg.bypass, neg: prod_b_reg[PROD_W-1]};
            ctl_d_reg <= '{valid: ctl_c_reg.valid, last: ctl_c_reg.last,
                           bypass: ctl_c_reg.bypass, neg: !pos_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg  <= {sample_in, e_next, s_next};
            drive_a_reg <= drive_next;
            prod_b_reg  <= PROD_W'(signed'(side_a_reg[S_W-1:0]))
                         * PROD_W'($signed({1'b0, drive_a_reg}));
            side_b_reg  <= side_a_reg;
            xmag_c_reg  <= prod_rnd[QF+XM_W-1:QF];
            side_c_reg  <= side_b_reg;
            num_d_reg   <= num_next;
            den_d_reg   <= den_next;
            side_d_reg  <= side_c_reg;
        end
    end

    assign ctl_o  = ctl_d_reg;
    assign num_o  = num_d_reg;
    assign den_o  = den_d_reg;
    assign side_o = side_d_reg;

endmodule

>>> rtl/vhe_div.sv
// Pipelined restoring divider for the soft-clip shaper, one quotient bit per
// stage. Depends on vhe_pkg.
module vhe_div #(
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  vhe_pkg::pipe_ctl_t            ctl_i,
    input  logic [vhe_pkg::NUM_W-1:0]     num_i,
    input  logic [vhe_pkg::DEN_W-1:0]     den_i,
    input  logic [SIDE_W-1:0]             side_i,
    output vhe_pkg::pipe_ctl_t            ctl_o,
    output logic [vhe_pkg::Q_W-1:0]       quo_o,
    output logic [SIDE_W-1:0]             side_o
);
    import vhe_pkg::*;

    pipe_ctl_t          ctl_reg  [Q_W];
    logic [DEN_W-1:0]   rem_reg  [Q_W];
    logic [Q_W-1:0]     low_reg  [Q_W];
    logic [Q_W-1:0]     quo_reg  [Q_W];
    logic [DEN_W-1:0]   den_reg  [Q_W];
    logic [SIDE_W-1:0]  side_reg [Q_W];

    // The quotient is known to fit Q_W bits, so the upper dividend bits start
    // out as a partial remainder below the divisor.
    for (genvar g = 0; g < Q_W; g++) begin : g_step
        pipe_ctl_t          ctl_src;
        logic [DEN_W-1:0]   rem_src;
        logic [Q_W-1:0]     low_src;
        logic [Q_W-1:0]     quo_src;
        logic [DEN_W-1:0]   den_src;
        logic [SIDE_W-1:0]  side_src;
        logic [DEN_W:0]     shifted;
        logic [DEN_W+1:0]   diff;
        logic               fits;

        if (g == 0) begin : g_first
            assign ctl_src  = ctl_i;
            assign rem_src  = DEN_W'(num_i[NUM_W-1:Q_W]);
            assign low_src  = num_i[Q_W-1:0];
            assign quo_src  = '0;
            assign den_src  = den_i;
            assign side_src = side_i;
        end else begin : g_chain
            assign ctl_src  = ctl_reg[g-1];
            assign rem_src  = rem_reg[g-1];
            assign low_src  = low_reg[g-1];
            assign quo_src  = quo_reg[g-1];
            assign den_src  = den_reg[g-1];
            assign side_src = side_reg[g-1];
        end

        assign shifted = {rem_src, low_src[Q_W-1]};
        assign diff    = {1'b0, shifted} - {2'b00, den_src};
        assign fits    = !diff[DEN_W+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[g] <= '0;
            end else if (en) begin
                ctl_reg[g] <= ctl_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                low_reg[g]  <= {low_src[Q_W-2:0], 1'b0};
                quo_reg[g]  <= {quo_src[Q_W-2:0], fits};
                den_reg[g]  <= den_src;
                side_reg[g] <= side_src;
            end
        end
    end

    assign ctl_o  = ctl_reg[Q_W-1];
    assign quo_o  = quo_reg[Q_W-1];
    assign side_o = side_reg[Q_W-1];

endmodule

>>> rtl/vhe_mix.sv
// Crossfade stages of the exciter: dry and shaped products, their sum, and the
// rounding back to 16 fraction bits. Depends on vhe_pkg.
module vhe_mix #(
    parameter int SAMPLE_WIDTH = vhe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  vhe_pkg::pipe_ctl_t                    ctl_i,
    input  logic [vhe_pkg::Q_W-1:0]               quo_i,
    input  logic [vhe_pkg::S_W+vhe_pkg::E_W+SAMPLE_WIDTH-1:0] side_i,
    output vhe_pkg::pipe_ctl_t                    ctl_o,
    output logic signed [vhe_pkg::MIX_W-1:0]      mix_o,
    output logic [SAMPLE_WIDTH-1:0]               raw_o
);
    import vhe_pkg::*;

    localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (QF - 1);

    logic signed [S_W-1:0]    s_in;
    logic [E_W-1:0]           e_in;
    logic [E_W-1:0]           e_dry;
    logic signed [SH_W-1:0]   shaped;

    pipe_ctl_t                ctl_p_reg, ctl_s_reg, ctl_m_reg;
    logic signed [SUM_W-1:0]  dry_p_reg, wet_p_reg, sum_s_reg;
    logic signed [MIX_W-1:0]  mix_m_reg;
    logic [SAMPLE_WIDTH-1:0]  raw_p_reg, raw_s_reg, raw_m_reg;

    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         sum_rnd;
    logic signed [MIX_W-1:0]  mix_next;

    always_comb begin
        s_in   = signed'(side_i[S_W-1:0]);
        e_in   = side_i[S_W+:E_W];
        e_dry  = E_ONE - e_in;
        shaped = ctl_i.neg ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
    end

    always_comb begin
        sum_mag = sum_s_reg[SUM_W-1] ? SUM_W'(-sum_s_reg) : SUM_W'(sum_s_reg);
        sum_rnd = sum_mag + SUM_HALF;
        if (sum_s_reg[SUM_W-1]) begin
            mix_next = -$signed({1'b0, sum_rnd[QF+MIX_W-2:QF]});
        end else begin
            mix_next = $signed({1'b0, sum_rnd[QF+MIX_W-2:QF]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_p_reg <= '0;
            ctl_s_reg <= '0;
            ctl_m_reg <= '0;
        end else if (en) begin
            ctl_p_reg <= ctl_i;
            ctl_s_reg <= ctl_p_reg;
            ctl_m_reg <= ctl_s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dry_p_reg <= SUM_W'(s_in) * SUM_W'($signed({1'b0, e_dry}));
            wet_p_reg <= SUM_W'(shaped) * SUM_W'($signed({1'b0, e_in}));
            raw_p_reg <= side_i[S_W+E_W+:SAMPLE_WIDTH];
            sum_s_reg <= dry_p_reg + wet_p_reg;
            raw_s_reg <= raw_p_reg;
            mix_m_reg <= mix_next;
            raw_m_reg <= raw_s_reg;
        end
    end

    assign ctl_o = ctl_m_reg;
    assign mix_o = mix_m_reg;
    assign raw_o = raw_m_reg;

endmodule

>>> rtl/velocity_harmonic_exciter_unit.sv
// Velocity harmonic exciter: each input item carries one signed audio sample
// (Q1.15 at the default SAMPLE_WIDTH of 16) and produces exactly one result
// item, in order. When the target velocity is at or below the recorded
// velocity the sample passes through untouched with the saturated flag clear;
// otherwise the sample is driven by 1 + 2e, where e = (target - recorded) / 127,
// soft-clipped asymmetrically (x / (1 + x) above zero, x / (1 - x/2) at or
// below), and crossfaded with the dry sample by e. Internal math uses 16
// fraction bits with round-half-away-from-zero at every step, and a result
// outside the sample range is clamped with the saturated flag set. The block
// accepts one item every clock cycle while the output is not held; each item
// passes in order through the pipeline: four front stages, a 17-stage
// divider that retires one quotient bit per stage for the soft clipper, three
// crossfade stages and the output register. Bypassed samples travel the same
// pipeline so order is kept. The whole pipeline advances together whenever the
// output register is empty or being taken, so a held output pauses every
// stage and no item is lost or repeated. Configuration registers are written
// through the cfg port, which is always ready; write them only while no item
// is in flight.
`include "velocity_harmonic_exciter_unit_assert.svh"

module velocity_harmonic_exciter_unit #(
    parameter int SAMPLE_WIDTH = vhe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    input  logic                                s_tlast,   // last_sample
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
    output logic [0:0]                          m_tuser,   // [0] saturated
    output logic                                m_tlast,   // last_out
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vhe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vhe_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import vhe_pkg::*;

    localparam int FRAC   = SAMPLE_WIDTH - 1;
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SIDE_W = S_W + E_W + SAMPLE_WIDTH;
    // Wide enough for the rescaled mix at any sample width, plus a sign bit.
    localparam int RES_W  = (SAMPLE_WIDTH + 2 > MIX_W + 1) ? SAMPLE_WIDTH + 2 : MIX_W + 1;

    localparam logic signed [RES_W-1:0] RES_HI =
        $signed((RES_W'(1) << (SAMPLE_WIDTH - 1)) - RES_W'(1));
    localparam logic signed [RES_W-1:0] RES_LO =
        $signed(~((RES_W'(1) << (SAMPLE_WIDTH - 1)) - RES_W'(1)));
    localparam logic [SAMPLE_WIDTH-1:0] SAT_HI = RES_HI[SAMPLE_WIDTH-1:0];
    localparam logic [SAMPLE_WIDTH-1:0] SAT_LO = RES_LO[SAMPLE_WIDTH-1:0];

    // Configuration registers.
    logic [VEL_W-1:0] recorded_reg;
    logic [VEL_W-1:0] target_reg;

    // Pipeline advance: every stage moves when the output register can take
    // a new item.
    logic en;

    pipe_ctl_t                 front_ctl;
    logic [NUM_W-1:0]          front_num;
    logic [DEN_W-1:0]          front_den;
    logic [SIDE_W-1:0]         front_side;

    pipe_ctl_t                 div_ctl;
    logic [Q_W-1:0]            div_quo;
    logic [SIDE_W-1:0]         div_side;

    pipe_ctl_t                 mix_ctl;
    logic signed [MIX_W-1:0]   mix_val;
    logic [SAMPLE_WIDTH-1:0]   mix_raw;

    logic signed [RES_W-1:0]   res_next;
    logic [SAMPLE_WIDTH-1:0]   sample_next;
    logic                      sat_next;

    logic                      out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]   sample_out_reg;
    logic                      sat_reg;
    logic                      last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recorded_reg <= '0;
            target_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RECORDED: begin
                    recorded_reg <= cfg_data[VEL_W-1:0];
                end
                CFG_TARGET: begin
                    target_reg <= cfg_data[VEL_W-1:0];
                end
                default: begin
                    // Writes to unassigned indexes are dropped.
                end
            endcase
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    vhe_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .sample_in (signed'(s_tdata[SAMPLE_WIDTH-1:0])),
        .last_in   (s_tlast),
        .recorded  (recorded_reg),
        .target    (target_reg),
        .ctl_o     (front_ctl),
        .num_o     (front_num),
        .den_o     (front_den),
        .side_o    (front_side)
    );

    vhe_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (front_ctl),
        .num_i   (front_num),
        .den_i   (front_den),
        .side_i  (front_side),
        .ctl_o   (div_ctl),
        .quo_o   (div_quo),
        .side_o  (div_side)
    );

    vhe_mix #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (div_ctl),
        .quo_i   (div_quo),
        .side_i  (div_side),
        .ctl_o   (mix_ctl),
        .mix_o   (mix_val),
        .raw_o   (mix_raw)
    );

    // Return the mix to the sample's own fraction width. Narrow samples are
    // rounded down from 16 fraction bits; wide samples are scaled up exactly.
    if (FRAC <= QF) begin : g_round_down
        localparam int RK = QF - FRAC;
        if (RK == 0) begin : g_same
            assign res_next = RES_W'(mix_val);
        end else begin : g_shift
            localparam logic [MIX_W-1:0] MIX_HALF = MIX_W'(1) << (RK - 1);
            logic [MIX_W-1:0] mix_mag;
            logic [MIX_W-1:0] mix_rnd;
            always_comb begin
                mix_mag = mix_val[MIX_W-1] ? MIX_W'(-mix_val) : MIX_W'(mix_val);
                mix_rnd = mix_mag + MIX_HALF;
                if (mix_val[MIX_W-1]) begin
                    res_next = -$signed(RES_W'(mix_rnd >> RK));
                end else begin
                    res_next = $signed(RES_W'(mix_rnd >> RK));
                end
            end
        end
    end else begin : g_scale_up
        assign res_next = RES_W'(mix_val) <<< (FRAC - QF);
    end

    // Clamp to the sample range; a bypassed item returns its input sample.
    always_comb begin
        sat_next    = 1'b0;
        sample_next = res_next[SAMPLE_WIDTH-1:0];
        if (res_next < RES_LO) begin
            sample_next = SAT_LO;
            sat_next    = 1'b1;
        end else if (res_next > RES_HI) begin
            sample_next = SAT_HI;
            sat_next    = 1'b1;
        end
        if (mix_ctl.bypass) begin
            sample_next = mix_raw;
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mix_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_out_reg <= sample_next;
            sat_reg        <= sat_next;
            last_reg       <= mix_ctl.last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = DATA_W'(sample_out_reg);
    assign m_tuser[0] = sat_reg;
    assign m_tlast    = last_reg;

    // A bypassed item must come out unchanged and never flagged as clamped.
    `VHE_ASSERT_NEXT(a_bypass_passes_sample, aclk, aresetn, en && mix_ctl.valid && mix_ctl.bypass, m_tvalid && !m_tuser[0] && (sample_out_reg == $past(mix_raw)))
    // A clamped result must sit exactly on one of the two rails.
    `VHE_ASSERT_IMPLY(a_saturated_on_rail, aclk, aresetn, m_tvalid && m_tuser[0], (sample_out_reg == SAT_LO) || (sample_out_reg == SAT_HI))

endmodule

>>> test/tb_top.sv
// Self-checking testbench for velocity_harmonic_exciter_unit: stream stimulus,
// an in-bench fixed-point predictor of the exciter and an in-order result check.
// Depends on rtl/vhe_pkg.sv and the block's top level.
module tb_top;
    import vhe_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int DW          = ((SW + 7) / 8) * 8;
    localparam int FRAC        = SW - 1;
    localparam int DRAIN_WAIT  = 40;       // more than the pipeline depth
    localparam int LONG_HOLD   = 300;      // receiver hold-off, far beyond pipeline depth
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 60;

    // Register indexes the block does not implement; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint Q16 = 65536;

    typedef struct {
        logic [SW-1:0] sample;
        logic          last;
    } sample_item_t;

    typedef struct {
        logic [SW-1:0] sample;
        logic          sat;
        logic          last;
    } excited_item_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata   = '0;
    logic          s_tlast   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [0:0]    m_tuser;
    logic          m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_RECORDED;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    velocity_harmonic_exciter_unit #(.SAMPLE_WIDTH(SW)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Bench-side copy of the two velocity registers, updated on each accepted write.
    logic [VEL_W-1:0] recorded_vel = '0;
    logic [VEL_W-1:0] target_vel   = '0;

    sample_item_t  sample_feed_q[$];
    excited_item_t expected_out_q[$];

    int  error_count  = 0;
    int  cycle_count  = 0;
    bit  in_taken     = 0;    // an input item was accepted at the last rising edge
    bit  out_taken    = 0;    // a result item was accepted at the last rising edge
    bit  tx_idle_on   = 0;    // sender inserts random gaps between items
    bit  rx_idle_on   = 0;    // receiver inserts random stalls between results
    int  tx_gap       = 0;
    int  rx_wait      = 0;
    int  rx_hold_req  = 0;    // request for a long hold-off, picked up by the receiver
    int  rx_hold_cnt  = 0;
    excited_item_t got, want;

    // Division rounded half away from zero; den is always positive here.
    function automatic longint div_round_away(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // Fixed-point exciter: all intermediates carry 16 fraction bits.
    function automatic excited_item_t excite_sample(sample_item_t item);
        excited_item_t r;
        longint v, d, e, drive, s, x, shaped, mix, res;
        longint lo, hi;
        lo = -(longint'(1) << FRAC);
        hi = (longint'(1) << FRAC) - 1;
        v  = longint'($signed(item.sample));
        r.last = item.last;
        r.sat  = 1'b0;
        if (target_vel <= recorded_vel) begin
            // Passthrough: sample unchanged, flag clear.
            r.sample = item.sample;
        end else begin
            d     = longint'(target_vel) - longint'(recorded_vel);
            e     = (d * Q16 + 63) / 127;
            drive = Q16 + 2 * e;
            s     = v * (longint'(1) << (16 - FRAC));
            x     = div_round_away(s * drive, Q16);
            if (x > 0) begin
                shaped = div_round_away(x * Q16, Q16 + x);
            end else begin
                shaped = div_round_away(x * 2 * Q16, 2 * Q16 - x);
            end
            mix = div_round_away(s * (Q16 - e) + shaped * e, Q16);
            res = div_round_away(mix, longint'(1) << (16 - FRAC));
            if (res < lo) begin
                res   = lo;
                r.sat = 1'b1;
            end else if (res > hi) begin
                res   = hi;
                r.sat = 1'b1;
            end
            r.sample = SW'(res);
        end
        return r;
    endfunction

    // Rising edge: timeout, register tracking, prediction of accepted items and
    // the in-order comparison of accepted results.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RECORDED: recorded_vel = cfg_data[VEL_W-1:0];
                    CFG_TARGET:   target_vel   = cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_out_q.push_back(excite_sample('{sample: s_tdata[SW-1:0],
                                                         last: s_tlast}));
                in_taken = 1;
            end
            if (m_tvalid && m_tready) begin
                out_taken  = 1;
                got.sample = m_tdata[SW-1:0];
                got.sat    = m_tuser[0];
                got.last   = m_tlast;
                if (expected_out_q.size() == 0) begin
                    $display("%0t: unexpected result item sample_out %0d saturated %0b last %0b",
                             $time, $signed(got.sample), got.sat, got.last);
                    error_count++;
                end else begin
                    want = expected_out_q.pop_front();
                    if (got.sample !== want.sample) begin
                        $display("%0t: sample_out expected %0d got %0d", $time,
                                 $signed(want.sample), $signed(got.sample));
                        error_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturated expected %0b got %0b", $time,
                                 want.sat, got.sat);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_out expected %0b got %0b", $time,
                                 want.last, got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Sender: drives the next pending item at the falling edge once the current
    // one has been taken, after a random gap when sender idling is enabled.
    // A valid that carries straight on to the next item is never dropped.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_feed_q.size() > 0) begin
                    s_tdata  <= DW'(sample_feed_q[0].sample);
                    s_tlast  <= sample_feed_q[0].last;
                    s_tvalid <= 1'b1;
                    void'(sample_feed_q.pop_front());
                    tx_gap = tx_idle_on ? $urandom_range(0, 8) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            in_taken = 0;
        end
    end

    // Receiver: after each result it takes, stalls for a random gap when receiver
    // idling is enabled, and serves a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                rx_wait = rx_idle_on ? $urandom_range(0, 8) : 0;
            end
            out_taken = 0;
            if (rx_hold_req > 0) begin
                rx_hold_cnt = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_cnt > 0) begin
                rx_hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_sample(logic [SW-1:0] smp, logic lst);
        sample_feed_q.push_back('{sample: smp, last: lst});
    endtask

    // Random samples: mostly uniform, with some clustered at both rails.
    task automatic push_random(int count);
        int kind;
        logic [SW-1:0] smp;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                smp = {1'b1, {(SW-1){1'b0}}} + SW'($urandom_range(0, 15));
            end else if (kind == 1) begin
                smp = {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(0, 15));
            end else begin
                smp = SW'($urandom);
            end
            push_sample(smp, $urandom_range(0, 7) == 0);
        end
    endtask

    // Register write at the falling edge, held until the channel accepts it.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Every item yields one result, so an empty expectation queue with nothing
    // left to send means the pipeline is empty; the extra wait is margin only.
    task automatic wait_drained();
        while (sample_feed_q.size() != 0 || s_tvalid || expected_out_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    initial begin
        logic [VEL_W-1:0] rec_set, tgt_set;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values give recorded equal to target, so the block passes through.
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b1);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h4000, 1'b0);
        push_sample(16'hC000, 1'b1);
        push_sample(16'h8001, 1'b0);
        wait_drained();

        // Full excitation; the target write carries a set bit 7 that must be dropped,
        // and writes to the unimplemented indexes must change nothing.
        write_reg(CFG_RECORDED, 8'h00);
        write_reg(CFG_TARGET, 8'hFF);
        write_reg(CFG_SPARE_2, 8'h7F);
        write_reg(CFG_SPARE_3, 8'hFF);
        push_sample(16'h8000, 1'b0);   // drives the mix below -1: clamps low
        push_sample(16'h8001, 1'b0);
        push_sample(16'hA000, 1'b1);
        push_sample(16'hC000, 1'b0);
        push_sample(16'hE000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h2000, 1'b0);
        push_sample(16'h4000, 1'b0);
        push_sample(16'h6000, 1'b1);
        push_sample(16'h7FFE, 1'b0);
        push_sample(16'h7FFF, 1'b0);   // top of the positive range
        push_sample(16'h5555, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin rec_set = 7'd127; tgt_set = 7'd127; end
                1: begin rec_set = 7'd0;   tgt_set = 7'd127; end
                2: begin rec_set = 7'd127; tgt_set = 7'd0;   end
                3: begin rec_set = 7'd0;   tgt_set = 7'd1;   end
                4: begin rec_set = 7'd126; tgt_set = 7'd127; end
                default: begin
                    rec_set = VEL_W'($urandom_range(0, 100));
                    tgt_set = VEL_W'($urandom_range(0, 127));
                end
            endcase
            // The phases cycle through the idling mixes, including stretches with none.
            tx_idle_on = (ph % 3) != 0;
            rx_idle_on = (ph % 4) >= 2;
            write_reg(CFG_RECORDED, {1'($urandom_range(0, 1)), rec_set});
            write_reg(CFG_TARGET,   {1'($urandom_range(0, 1)), tgt_set});

            if (ph == 1) begin
                // Receiver holds off while the sender keeps offering items, so the
                // pipeline fills and the input side has to stall.
                rx_hold_req = LONG_HOLD;
                push_random(PHASE_ITEMS);
            end else if (ph == 3) begin
                // Sender pauses until every outstanding result has come back.
                push_random(PHASE_ITEMS / 2);
                wait_drained();
                push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                push_random(PHASE_ITEMS);
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> velocity_harmonic_exciter_unit.f
+incdir+rtl
rtl/vhe_pkg.sv
rtl/vhe_front.sv
rtl/vhe_div.sv
rtl/vhe_mix.sv
rtl/velocity_harmonic_exciter_unit.sv
test/tb_top.sv
